// ===== hdl/sqd_pkg.sv =====
// Shared constants, codes and types of the shortest-queue dispatcher.
`default_nettype none

package sqd_pkg;

	localparam int NUM_LINES_DEF  = 8;
	localparam int LINE_DEPTH_DEF = 64;
	localparam int ID_BITS_DEF    = 16;

	localparam int RAND_BITS     = 16;
	localparam int SERVER_BITS   = 3;
	localparam int LINE_IDX_BITS = 3;
	localparam int STATUS_BITS   = 2;
	localparam int CFG_BITS      = 4;

	// remainder bits resolved per clock in the modulo unit
	localparam int MOD_STEP = 8;

	localparam logic OP_ENQ   = 1'b0;
	localparam logic OP_SERVE = 1'b1;

	localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

	localparam logic [CFG_BITS-1:0] LINES_IN_USE_RST = 4'd1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_PICK,
		S_RESP
	} fsm_state_t;

endpackage

`default_nettype wire

// ===== hdl/sqd_if.sv =====
// Request, result and configuration channel interfaces.
`default_nettype none

interface sqd_req_if import sqd_pkg::*; #(
	parameter int ID_BITS = ID_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [ID_BITS-1:0]     item_id;
	logic [SERVER_BITS-1:0] server;
	logic [RAND_BITS-1:0]   rand_value;

	modport source (output valid, op, item_id, server, rand_value, input ready);
	modport sink (input valid, op, item_id, server, rand_value, output ready);
endinterface

interface sqd_res_if import sqd_pkg::*; #(
	parameter int ID_BITS = ID_BITS_DEF
) ();
	logic                     valid;
	logic                     ready;
	logic [LINE_IDX_BITS-1:0] line_index;
	logic [ID_BITS-1:0]       popped_id;
	logic                     got_item;
	logic [STATUS_BITS-1:0]   status;

	modport source (output valid, line_index, popped_id, got_item, status, input ready);
	modport sink (input valid, line_index, popped_id, got_item, status, output ready);
endinterface

interface sqd_cfg_if import sqd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sqd_mod.sv =====
// Multi-cycle remainder unit: random draw modulo a small candidate count.
`default_nettype none

module sqd_mod import sqd_pkg::*; #(
	parameter int DIV_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAND_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0]  divisor,
	output logic                 last,
	output logic [DIV_BITS-1:0]  remainder
);

	localparam int STEPS    = (RAND_BITS + MOD_STEP - 1) / MOD_STEP;
	localparam int CNT_BITS = $clog2(STEPS + 1);
	localparam int PAD_BITS = STEPS * MOD_STEP;

	logic [PAD_BITS-1:0] sh_q;
	logic [DIV_BITS-1:0] div_q;
	logic [DIV_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS:0]   part;
	logic [DIV_BITS-1:0] rem_next;

	// restoring remainder, one dividend bit per inner step
	always_comb begin
		rem_next = rem_q;
		part     = '0;
		for (int b = 0; b < MOD_STEP; b++) begin
			part = {rem_next, sh_q[PAD_BITS-1-b]};
			if (part >= {1'b0, div_q}) begin
				part = part - {1'b0, div_q};
			end
			rem_next = part[DIV_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= PAD_BITS'(dividend);
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q  <= sh_q << MOD_STEP;
			rem_q <= rem_next;
		end
	end

	assign last      = (cnt_q == CNT_BITS'(1));
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hdl/sqd_store.sv =====
// Single-port line store of item identifiers, registered read.
`default_nettype none

module sqd_store #(
	parameter int ID_BITS    = 16,
	parameter int DEPTH      = 512,
	parameter int ADDR_BITS  = 9
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [ID_BITS-1:0]   wr_data,
	output logic [ID_BITS-1:0]   rd_data
);

	logic [ID_BITS-1:0] mem_q [DEPTH];
	logic [ID_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/shortest_queue_dispatcher_top.sv =====
// Shortest-queue dispatcher with work stealing over ring lines in one store.
// A request goes through S_PICK and S_RESP into the result register, with S_MOD
// first when the candidate set holds more than one line (tie break or steal);
// a new request is taken only in S_IDLE, after the result is loaded. The
// remainder unit in S_MOD works through 8 bits of the draw per cycle.
// Reset: line counts and head pointers clear, lines in use returns to 1;
// the store itself is not cleared and needs no sweep.
`default_nettype none

module shortest_queue_dispatcher_top import sqd_pkg::*; #(
	parameter int NUM_LINES  = NUM_LINES_DEF,
	parameter int LINE_DEPTH = LINE_DEPTH_DEF,
	parameter int ID_BITS    = ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sqd_cfg_if.sink   cfg,
	sqd_req_if.sink   request,
	sqd_res_if.source result
);

	localparam int LB          = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int NL_BITS     = $clog2(NUM_LINES + 1);
	localparam int CNT_BITS    = $clog2(LINE_DEPTH + 1);
	localparam int PTR_BITS    = $clog2(LINE_DEPTH);
	localparam int STORE_DEPTH = NUM_LINES * LINE_DEPTH;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

	fsm_state_t state_q, state_d;

	logic [CFG_BITS-1:0] lines_q;
	logic [NL_BITS-1:0]  nl;
	logic [NUM_LINES-1:0] act, nonempty, own, is_min, elig;
	logic [NL_BITS-1:0]  div;
	logic                req_xfer;

	logic [CNT_BITS-1:0] count_q [NUM_LINES];
	logic [PTR_BITS-1:0] head_q [NUM_LINES];

	logic                 op_q;
	logic [ID_BITS-1:0]   id_q;
	logic [NUM_LINES-1:0] elig_q;
	logic [NL_BITS-1:0]   div_q;

	logic                mod_start, mod_last;
	logic [NL_BITS-1:0]  mod_rem, want, seen;

	logic [NUM_LINES-1:0] sel;
	logic [LB-1:0]        pick_line;
	logic                 found, full;
	logic [CNT_BITS-1:0]  pick_cnt;
	logic [PTR_BITS-1:0]  pick_head, head_next, tail;
	logic [CNT_BITS:0]    tsum;
	logic [ADDR_BITS-1:0] base, addr;
	logic                 do_write, do_read;
	logic [ID_BITS-1:0]   rd_data;

	logic [LB-1:0]            res_line_q;
	logic                     res_got_q;
	logic [STATUS_BITS-1:0]   res_status_q;
	logic                     out_load;
	logic                     out_valid_q;
	logic [LINE_IDX_BITS-1:0] out_line_q;
	logic [ID_BITS-1:0]       out_id_q;
	logic                     out_got_q;
	logic [STATUS_BITS-1:0]   out_status_q;

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= LINES_IN_USE_RST;
		end else if (cfg.valid) begin
			lines_q <= cfg.data;
		end
	end

	always_comb begin
		if (lines_q == '0) begin
			nl = NL_BITS'(1);
		end else if (int'(lines_q) > NUM_LINES) begin
			nl = NL_BITS'(NUM_LINES);
		end else begin
			nl = NL_BITS'(lines_q);
		end
	end

	// candidate lines, formed from the counts as the request is taken
	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			act[i]      = (i < int'(nl));
			nonempty[i] = act[i] && (count_q[i] != '0);
			own[i]      = nonempty[i] && (i == int'(request.server));
			is_min[i]   = act[i];
			for (int j = 0; j < NUM_LINES; j++) begin
				if ((j < int'(nl)) && (count_q[j] < count_q[i])) begin
					is_min[i] = 1'b0;
				end
			end
		end
		if (request.op == OP_ENQ) begin
			elig = is_min;
		end else if (|own) begin
			elig = own;
		end else begin
			elig = nonempty;
		end
		div = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			div = div + NL_BITS'(elig[i]);
		end
	end

	assign request.ready = (state_q == S_IDLE);
	assign req_xfer      = request.valid && (state_q == S_IDLE);
	assign mod_start     = req_xfer && (div > NL_BITS'(1));

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q   <= request.op;
			id_q   <= request.item_id;
			elig_q <= elig;
			div_q  <= div;
		end
	end

	sqd_mod #(
		.DIV_BITS (NL_BITS)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (request.rand_value),
		.divisor   (div),
		.last      (mod_last),
		.remainder (mod_rem)
	);

	assign want = (div_q > NL_BITS'(1)) ? mod_rem : '0;

	// take the want-th candidate, counting from line 0
	always_comb begin
		sel       = '0;
		pick_line = '0;
		seen      = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			seen = '0;
			for (int j = 0; j < i; j++) begin
				seen = seen + NL_BITS'(elig_q[j]);
			end
			sel[i] = elig_q[i] && (seen == want);
		end
		for (int i = 0; i < NUM_LINES; i++) begin
			if (sel[i]) begin
				pick_line = pick_line | LB'(i);
			end
		end
	end

	assign found     = (div_q != '0);
	assign pick_cnt  = count_q[pick_line];
	assign pick_head = head_q[pick_line];
	assign full      = (pick_cnt == CNT_BITS'(LINE_DEPTH));
	assign tsum      = (CNT_BITS+1)'(pick_head) + (CNT_BITS+1)'(pick_cnt);
	assign tail      = (tsum >= (CNT_BITS+1)'(LINE_DEPTH)) ?
			PTR_BITS'(tsum - (CNT_BITS+1)'(LINE_DEPTH)) : PTR_BITS'(tsum);
	assign head_next = (pick_head == PTR_BITS'(LINE_DEPTH - 1)) ? '0 : pick_head + 1'b1;
	assign base      = ADDR_BITS'(pick_line) * ADDR_BITS'(LINE_DEPTH);
	assign addr      = base + ((op_q == OP_ENQ) ? ADDR_BITS'(tail) : ADDR_BITS'(pick_head));
	assign do_write  = (state_q == S_PICK) && (op_q == OP_ENQ) && !full;
	assign do_read   = (state_q == S_PICK) && (op_q == OP_SERVE) && found;

	sqd_store #(
		.ID_BITS   (ID_BITS),
		.DEPTH     (STORE_DEPTH),
		.ADDR_BITS (ADDR_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (do_write),
		.rd_en   (do_read),
		.addr    (addr),
		.wr_data (id_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else if (do_write) begin
			count_q[pick_line] <= pick_cnt + 1'b1;
		end else if (do_read) begin
			count_q[pick_line] <= pick_cnt - 1'b1;
			head_q[pick_line]  <= head_next;
		end
	end

	// hold the result until the popped word arrives from the store
	always_ff @(posedge clk) begin
		if (state_q == S_PICK) begin
			if (op_q == OP_ENQ) begin
				res_line_q   <= pick_line;
				res_got_q    <= 1'b0;
				res_status_q <= full ? STATUS_FULL : STATUS_OK;
			end else if (found) begin
				res_line_q   <= pick_line;
				res_got_q    <= 1'b1;
				res_status_q <= STATUS_OK;
			end else begin
				res_line_q   <= '0;
				res_got_q    <= 1'b0;
				res_status_q <= STATUS_EMPTY;
			end
		end
	end

	assign out_load = (state_q == S_RESP) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_line_q   <= LINE_IDX_BITS'(res_line_q);
			out_id_q     <= res_got_q ? rd_data : '0;
			out_got_q    <= res_got_q;
			out_status_q <= res_status_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.line_index = out_line_q;
	assign result.popped_id  = out_id_q;
	assign result.got_item   = out_got_q;
	assign result.status     = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					state_d = mod_start ? S_MOD : S_PICK;
				end
			end
			S_MOD: begin
				if (mod_last) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && div_q != '0) |-> $onehot(sel))
		else $error("pick does not select exactly one line");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && op_q == OP_SERVE && div_q != '0) |-> (pick_cnt != '0))
		else $error("pop from an empty line");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && div_q > NL_BITS'(1)) |-> (mod_rem < div_q))
		else $error("remainder not below candidate count");

	a_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> (state_q == S_MOD || state_q == S_PICK))
		else $error("request transfer did not start work");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the shortest-queue dispatcher: directed and random traffic.

module tb;
	import sqd_pkg::*;

	localparam int HOLD_CYCLES   = 250;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CAP     = 5000;

	typedef struct packed {
		logic [LINE_IDX_BITS-1:0] line_index;
		logic [ID_BITS_DEF-1:0]   popped_id;
		logic                     got_item;
		logic [STATUS_BITS-1:0]   status;
	} dispatch_t;

	// Mirror of the lines and the dispatch decisions, plus the results still owed.
	class dispatch_tracker;
		logic [ID_BITS_DEF-1:0] ring [NUM_LINES_DEF][LINE_DEPTH_DEF];
		int unsigned head [NUM_LINES_DEF];
		int unsigned tail [NUM_LINES_DEF];
		int unsigned fill [NUM_LINES_DEF];
		logic [CFG_BITS-1:0] lines_in_use;
		dispatch_t awaited [$];
		int errors;

		function new();
			foreach (head[i]) begin
				head[i] = 0;
				tail[i] = 0;
				fill[i] = 0;
			end
			lines_in_use = LINES_IN_USE_RST;
			errors = 0;
		endfunction

		function void set_lines(logic [CFG_BITS-1:0] value);
			lines_in_use = value;
		endfunction

		function int unsigned active_lines();
			if (lines_in_use == 0)
				return 1;
			if (lines_in_use > NUM_LINES_DEF)
				return NUM_LINES_DEF;
			return lines_in_use;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(logic op, logic [ID_BITS_DEF-1:0] id,
				logic [SERVER_BITS-1:0] server, logic [RAND_BITS-1:0] draw);
			dispatch_t res;
			int unsigned nl, best, ties, want, seen, ln;
			bit picked;
			nl = active_lines();
			res = '0;
			picked = 1'b0;
			if (op == OP_ENQ) begin
				if (nl > 1) begin
					best = fill[0];
					ties = 0;
					seen = 0;
					for (int i = 1; i < nl; i++)
						if (fill[i] < best)
							best = fill[i];
					for (int i = 0; i < nl; i++)
						if (fill[i] == best)
							ties++;
					want = draw % ties;
					// take the want-th tied line, counting from line 0
					for (int i = 0; i < nl; i++) begin
						if (fill[i] == best) begin
							if (seen == want && !picked) begin
								res.line_index = LINE_IDX_BITS'(i);
								picked = 1'b1;
							end
							seen++;
						end
					end
				end
				ln = res.line_index;
				if (fill[ln] >= LINE_DEPTH_DEF) begin
					res.status = STATUS_FULL;
				end else begin
					ring[ln][tail[ln]] = id;
					tail[ln] = (tail[ln] + 1) % LINE_DEPTH_DEF;
					fill[ln]++;
				end
			end else begin
				if (nl == 1) begin
					picked = (fill[0] != 0);
				end else if (server < nl && fill[server] != 0) begin
					res.line_index = server;
					picked = 1'b1;
				end else begin
					// steal: the draw, modulo their number, picks among the non-empty lines
					ties = 0;
					seen = 0;
					for (int i = 0; i < nl; i++)
						if (fill[i] != 0)
							ties++;
					if (ties != 0) begin
						want = draw % ties;
						for (int i = 0; i < nl; i++) begin
							if (fill[i] != 0) begin
								if (seen == want && !picked) begin
									res.line_index = LINE_IDX_BITS'(i);
									picked = 1'b1;
								end
								seen++;
							end
						end
					end
				end
				if (picked) begin
					ln = res.line_index;
					res.popped_id = ring[ln][head[ln]];
					res.got_item = 1'b1;
					head[ln] = (head[ln] + 1) % LINE_DEPTH_DEF;
					fill[ln]--;
				end else begin
					res.line_index = '0;
					res.status = STATUS_EMPTY;
				end
			end
			awaited.push_back(res);
		endfunction

		function void check_result(dispatch_t seen);
			dispatch_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing outstanding: line_index %0d popped_id %0h status %0d",
					seen.line_index, seen.popped_id, seen.status);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (seen.line_index !== want.line_index) begin
				$error("line_index: expected %0d, actual %0d", want.line_index, seen.line_index);
				errors++;
			end
			if (seen.popped_id !== want.popped_id) begin
				$error("popped_id: expected %0h, actual %0h", want.popped_id, seen.popped_id);
				errors++;
			end
			if (seen.got_item !== want.got_item) begin
				$error("got_item: expected %0d, actual %0d", want.got_item, seen.got_item);
				errors++;
			end
			if (seen.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, seen.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sqd_cfg_if cfg_bus ();
	sqd_req_if req_bus ();
	sqd_res_if res_bus ();

	shortest_queue_dispatcher_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.request(req_bus),
		.result(res_bus)
	);

	dispatch_tracker tracker;
	bit idle_on;
	int hold_seq;

	always #4 clk = ~clk;

	task automatic send_request(input logic op, input logic [ID_BITS_DEF-1:0] id,
			input logic [SERVER_BITS-1:0] server, input logic [RAND_BITS-1:0] draw);
		req_bus.valid      <= 1'b1;
		req_bus.op         <= op;
		req_bus.item_id    <= id;
		req_bus.server     <= server;
		req_bus.rand_value <= draw;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		tracker.note_request(op, id, server, draw);
	endtask

	task automatic idle_sender(input int cycles);
		req_bus.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		req_bus.valid <= 1'b0;
		while (tracker.pending() != 0 && guard < DRAIN_CAP) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_lines(input logic [CFG_BITS-1:0] value);
		wait_drained();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		tracker.set_lines(value);
	endtask

	task automatic run_phase(input logic [CFG_BITS-1:0] lines, input int items,
			input int enq_pct, input bit idle, input bit hold, input bit pause);
		logic op;
		logic [ID_BITS_DEF-1:0] id;
		logic [SERVER_BITS-1:0] server;
		logic [RAND_BITS-1:0] draw;
		write_lines(lines);
		idle_on = idle;
		for (int n = 0; n < items; n++) begin
			// let the receiver hold off while requests keep coming
			if (hold && n == 8)
				hold_seq++;
			if (pause && n == items / 2)
				wait_drained();
			if (idle && $urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 15));
			op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_SERVE;
			case ($urandom_range(0, 9))
				0: id = '0;
				1: id = '1;
				default: id = ID_BITS_DEF'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 9))
				0: draw = '0;
				1: draw = '1;
				2, 3: draw = RAND_BITS'($urandom_range(0, 15));
				default: draw = RAND_BITS'($urandom_range(0, 65535));
			endcase
			server = SERVER_BITS'($urandom_range(0, 7));
			send_request(op, id, server, draw);
		end
	endtask

	// result side: check every transfer, stall in bursts or for one long hold-off
	initial begin
		int stall_left;
		int hold_left;
		int hold_seen;
		dispatch_t seen;
		stall_left = 0;
		hold_left = 0;
		hold_seen = 0;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready) begin
				seen.line_index = res_bus.line_index;
				seen.popped_id  = res_bus.popped_id;
				seen.got_item   = res_bus.got_item;
				seen.status     = res_bus.status;
				tracker.check_result(seen);
			end
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 14);
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		tracker = new();
		idle_on = 1'b0;
		hold_seq = 0;
		req_bus.valid      <= 1'b0;
		req_bus.op         <= OP_ENQ;
		req_bus.item_id    <= '0;
		req_bus.server     <= '0;
		req_bus.rand_value <= '0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.data       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one common line after reset: empty serves, extreme ids, any server takes line 0
		send_request(OP_SERVE, 16'h0000, 3'd0, 16'h0000);
		send_request(OP_SERVE, 16'hFFFF, 3'd7, 16'hFFFF);
		send_request(OP_ENQ, 16'h0000, 3'd7, 16'hFFFF);
		send_request(OP_ENQ, 16'hFFFF, 3'd0, 16'h0000);
		send_request(OP_ENQ, 16'h1234, 3'd5, 16'h00FF);
		send_request(OP_SERVE, 16'hFFFF, 3'd7, 16'hFFFF);
		send_request(OP_SERVE, 16'h0000, 3'd3, 16'h0001);

		// all eight lines: tie breaks, own-line serve, stealing, all empty
		write_lines(4'd8);
		send_request(OP_ENQ, 16'hA5A5, 3'd0, 16'h0000);
		send_request(OP_ENQ, 16'h5A5A, 3'd0, 16'hFFFF);
		send_request(OP_ENQ, 16'h0001, 3'd0, 16'h0007);
		send_request(OP_SERVE, 16'h0000, 3'd1, 16'h0000);
		send_request(OP_SERVE, 16'h0000, 3'd2, 16'hFFFF);
		send_request(OP_SERVE, 16'h0000, 3'd5, 16'h0003);
		send_request(OP_SERVE, 16'h0000, 3'd6, 16'h0000);
		send_request(OP_SERVE, 16'h0000, 3'd0, 16'h8000);

		// three lines: a server beyond the lines in use goes straight to stealing
		write_lines(4'd3);
		send_request(OP_ENQ, 16'h8000, 3'd0, 16'h0001);
		send_request(OP_SERVE, 16'h0000, 3'd7, 16'h0000);
		send_request(OP_SERVE, 16'h0000, 3'd6, 16'hFFFF);

		// lines, items, enqueue share, idling, long hold-off, mid-phase drain
		run_phase(4'd1, 100, 90, 1'b1, 1'b0, 1'b0);
		run_phase(4'd1, 70, 20, 1'b1, 1'b0, 1'b0);
		run_phase(4'd8, 120, 60, 1'b1, 1'b1, 1'b0);
		run_phase(4'd0, 60, 50, 1'b0, 1'b0, 1'b0);
		run_phase(4'd3, 220, 95, 1'b1, 1'b0, 1'b0);
		run_phase(4'd15, 120, 30, 1'b1, 1'b0, 1'b0);
		run_phase(4'd5, 100, 50, 1'b1, 1'b0, 1'b1);
		run_phase(4'd2, 80, 40, 1'b1, 1'b0, 1'b0);
		run_phase(4'd9, 80, 50, 1'b1, 1'b0, 1'b0);
		run_phase(4'd6, 60, 20, 1'b1, 1'b0, 1'b0);
		run_phase(4'd4, 60, 50, 1'b0, 1'b0, 1'b0);
		run_phase(4'd8, 80, 50, 1'b0, 1'b0, 1'b0);

		wait_drained();
		if (tracker.pending() != 0) begin
			$error("%0d results never arrived", tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("shortest_queue_dispatcher_top: match");
		else
			$display("shortest_queue_dispatcher_top: mismatch");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("shortest_queue_dispatcher_top: mismatch");
		$finish;
	end

endmodule
